@@ rtl/gns_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, field widths and the quarter-wave sine table for the noise sampler.
package gns_pkg;

  localparam int MODE_W   = 1;
  localparam int INDEX_W  = 12;
  localparam int ANGLE_W  = 9;
  localparam int COORD_W  = 14;
  localparam int NOISE_W  = 16;
  localparam int TRIG_W   = 16;

  localparam int FULL_TURN    = 360;
  localparam int HALF_TURN    = 180;
  localparam int QUARTER_TURN = 90;
  localparam int THREE_QUARTER_TURN = 270;
  localparam int NOISE_MAX    = 32767;

  localparam logic [MODE_W-1:0] MODE_WRITE  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] cell_index;
    logic [ANGLE_W-1:0] angle_degrees;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
  } gns_in_t;

  typedef struct packed {
    logic signed [NOISE_W-1:0] noise_value;
  } gns_out_t;

  localparam logic [14:0] QUARTER_SINE [0:90] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
    15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
    15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
    15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
    15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
    15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
    15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
    15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421, 15'd13583,
    15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466, 15'd14598,
    15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396,
    15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
    15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Q1.14 sine of an angle below two full turns.
  function automatic logic signed [TRIG_W-1:0] sine_q14(input logic [9:0] deg);
    logic [9:0]               a;
    logic [6:0]               r;
    logic [6:0]               idx;
    logic                     mirror;
    logic                     neg;
    logic signed [TRIG_W-1:0] mag;
    a = (deg >= 10'(FULL_TURN)) ? deg - 10'(FULL_TURN) : deg;
    if (a < 10'(QUARTER_TURN)) begin
      r = a[6:0];
      mirror = 1'b0;
      neg = 1'b0;
    end else if (a < 10'(HALF_TURN)) begin
      r = 7'(a - 10'(QUARTER_TURN));
      mirror = 1'b1;
      neg = 1'b0;
    end else if (a < 10'(THREE_QUARTER_TURN)) begin
      r = 7'(a - 10'(HALF_TURN));
      mirror = 1'b0;
      neg = 1'b1;
    end else begin
      r = 7'(a - 10'(THREE_QUARTER_TURN));
      mirror = 1'b1;
      neg = 1'b1;
    end
    idx = mirror ? 7'(QUARTER_TURN) - r : r;
    mag = $signed({1'b0, QUARTER_SINE[idx]});
    return neg ? -mag : mag;
  endfunction

endpackage

@@ rtl/gns_stream_if.sv @@
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload per transfer.
interface gns_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/gns_lattice.sv @@
`timescale 1ns / 1ps
// Gradient angle lattice: two row copies, each written together and read at two cells.
module gns_lattice #(
  parameter int DEPTH = 4096
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        wen,
  input  logic [$clog2(DEPTH)-1:0]    waddr,
  input  logic [gns_pkg::ANGLE_W-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0]    raddr [4],
  output logic [gns_pkg::ANGLE_W-1:0] rdata [4]
);
  import gns_pkg::*;

  logic [ANGLE_W-1:0] mem_lo [DEPTH];
  logic [ANGLE_W-1:0] mem_hi [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem_lo[waddr] <= wdata;
      mem_hi[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata[0] <= mem_lo[raddr[0]];
      rdata[1] <= mem_lo[raddr[1]];
      rdata[2] <= mem_hi[raddr[2]];
      rdata[3] <= mem_hi[raddr[3]];
    end
  end

endmodule

@@ rtl/gradient_noise_2d_sampler_unit.sv @@
`timescale 1ns / 1ps
// Top level of the 2D gradient noise sampler: lattice writes and pipelined sampling.
// Throughput: one item per cycle; a write item takes one slot and gives no result.
// The whole pipeline holds while a finished result waits at the output register.
// Reset clears the valid bits only; lattice cells are undefined until written.
module gradient_noise_2d_sampler_unit #(
  parameter int GRID_SIZE       = 64,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  gns_stream_if.sink   sample_in,
  gns_stream_if.source noise_out
);
  import gns_pkg::*;

  localparam int F     = COORD_FRAC_BITS;
  localparam int IW    = COORD_W - F;
  localparam int CW    = $clog2(GRID_SIZE);
  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int RS    = IW + 8;
  localparam int PW    = IW + RS;
  localparam int DW    = F + 17;
  localparam int XW    = 2 * F + 17;
  localparam int HW    = XW - 16;
  localparam int HPW   = HW + F + 2;
  localparam int LW    = F + 17;
  localparam int TW    = HPW + 17;
  localparam int RW    = TW + 1;

  localparam logic [PW-1:0]        RECIP  = PW'((1 << RS) / GRID_SIZE);
  localparam logic [F:0]           ONE    = (F + 1)'(1) << F;
  localparam logic [CW-1:0]        LAST   = CW'(GRID_SIZE - 1);
  localparam logic signed [RW-1:0] HALF   = RW'(1) << (3 * F - 1);
  localparam logic signed [RW-1:0] SAT_HI = RW'(NOISE_MAX);
  localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

  logic adv;

  // stage 1
  logic [IW-1:0]      ix_in, iy_in;
  logic [PW-1:0]      px_in, py_in;
  logic [ANGLE_W-1:0] wang_in;
  logic               wok_in;
  logic               v1;
  logic [MODE_W-1:0]  mode1;
  logic [AW-1:0]      waddr1;
  logic [ANGLE_W-1:0] wang1;
  logic               wok1;
  logic [IW-1:0]      ix1, iy1, qx1, qy1;
  logic [F-1:0]       fx1, fy1;

  // stage 2
  logic [IW-1:0]      rx, ry;
  logic [CW-1:0]      cx0_next, cy0_next;
  logic               v2;
  logic [MODE_W-1:0]  mode2;
  logic [AW-1:0]      waddr2;
  logic [ANGLE_W-1:0] wang2;
  logic               wok2;
  logic [CW-1:0]      cx0, cy0;
  logic [F-1:0]       fx2, fy2;

  // stage 3
  logic [CW-1:0]      cx1, cy1;
  logic [AW-1:0]      raddr_next [4];
  logic               v3;
  logic [MODE_W-1:0]  mode3;
  logic [AW-1:0]      waddr3;
  logic [ANGLE_W-1:0] wang3;
  logic               wok3;
  logic [AW-1:0]      raddr3 [4];
  logic [F-1:0]       fx3, fy3;
  logic               lat_wen;

  // stage 4
  logic               v4;
  logic [ANGLE_W-1:0] ang4 [4];
  logic [F-1:0]       fx4, fy4;

  // stage 5
  logic                     v5;
  logic signed [TRIG_W-1:0] cs5 [4];
  logic signed [TRIG_W-1:0] sn5 [4];
  logic [F-1:0]             fx5, fy5;

  // stage 6
  logic signed [F:0]    dxs [2];
  logic signed [F:0]    dys [2];
  logic signed [DW-1:0] pc [4];
  logic signed [DW-1:0] ps [4];
  logic                 v6;
  logic signed [DW-1:0] dot6 [4];
  logic [F-1:0]         fx6, fy6;

  // stage 7
  logic [F:0]           wx0, wx1;
  logic signed [XW-1:0] qa [2];
  logic signed [XW-1:0] qb [2];
  logic                 v7;
  logic signed [XW-1:0] nx7 [2];
  logic [F-1:0]         fy7;

  // stage 8
  logic [F:0]            wy [2];
  logic [LW-1:0]         lo_next [2];
  logic signed [HPW-1:0] hi_next [2];
  logic                  v8;
  logic [LW-1:0]         lo8 [2];
  logic signed [HPW-1:0] hi8 [2];

  // stage 9
  logic signed [HPW:0]   hs;
  logic [LW:0]           ls;
  logic                  v9;
  logic signed [TW-1:0]  total9;

  // output
  logic signed [RW-1:0]      rsum, shv;
  logic signed [NOISE_W-1:0] noise_next;
  logic                      ovalid;
  logic signed [NOISE_W-1:0] onoise;

  assign adv = !ovalid || noise_out.ready;
  assign sample_in.ready = adv;
  assign noise_out.valid = ovalid;
  assign noise_out.payload.noise_value = onoise;

  // stage 1: split coordinates, estimate cell quotient, reduce write angle, check cell index
  assign ix_in = sample_in.payload.x_coord[COORD_W-1:F];
  assign iy_in = sample_in.payload.y_coord[COORD_W-1:F];
  assign px_in = PW'(ix_in) * RECIP;
  assign py_in = PW'(iy_in) * RECIP;
  assign wang_in = (sample_in.payload.angle_degrees >= ANGLE_W'(FULL_TURN)) ?
                   sample_in.payload.angle_degrees - ANGLE_W'(FULL_TURN) :
                   sample_in.payload.angle_degrees;
  assign wok_in = int'(sample_in.payload.cell_index) < CELLS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= sample_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1  <= sample_in.payload.mode;
      waddr1 <= AW'(sample_in.payload.cell_index);
      wang1  <= wang_in;
      wok1   <= wok_in;
      ix1    <= ix_in;
      iy1    <= iy_in;
      qx1    <= px_in[PW-1:RS];
      qy1    <= py_in[PW-1:RS];
      fx1    <= sample_in.payload.x_coord[F-1:0];
      fy1    <= sample_in.payload.y_coord[F-1:0];
    end
  end

  // stage 2: remainder with one correction step
  assign rx = ix1 - IW'(int'(qx1) * GRID_SIZE);
  assign ry = iy1 - IW'(int'(qy1) * GRID_SIZE);
  assign cx0_next = (int'(rx) >= GRID_SIZE) ? CW'(int'(rx) - GRID_SIZE) : CW'(rx);
  assign cy0_next = (int'(ry) >= GRID_SIZE) ? CW'(int'(ry) - GRID_SIZE) : CW'(ry);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode2  <= mode1;
      waddr2 <= waddr1;
      wang2  <= wang1;
      wok2   <= wok1;
      cx0    <= cx0_next;
      cy0    <= cy0_next;
      fx2    <= fx1;
      fy2    <= fy1;
    end
  end

  // stage 3: neighbour cells with wrap, corner addresses
  assign cx1 = (cx0 == LAST) ? '0 : cx0 + CW'(1);
  assign cy1 = (cy0 == LAST) ? '0 : cy0 + CW'(1);
  assign raddr_next[0] = AW'(int'(cy0) * GRID_SIZE + int'(cx0));
  assign raddr_next[1] = AW'(int'(cy0) * GRID_SIZE + int'(cx1));
  assign raddr_next[2] = AW'(int'(cy1) * GRID_SIZE + int'(cx0));
  assign raddr_next[3] = AW'(int'(cy1) * GRID_SIZE + int'(cx1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode3  <= mode2;
      waddr3 <= waddr2;
      wang3  <= wang2;
      wok3   <= wok2;
      raddr3 <= raddr_next;
      fx3    <= fx2;
      fy3    <= fy2;
    end
  end

  // stage 4: lattice write and corner reads at the same point keep item order
  assign lat_wen = adv && v3 && (mode3 == MODE_WRITE) && wok3;

  gns_lattice #(
    .DEPTH (CELLS)
  ) u_lattice (
    .clk   (clk),
    .en    (adv),
    .wen   (lat_wen),
    .waddr (waddr3),
    .wdata (wang3),
    .raddr (raddr3),
    .rdata (ang4)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3 && (mode3 == MODE_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fx4 <= fx3;
      fy4 <= fy3;
    end
  end

  // stage 5: gradient vectors
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        cs5[k] <= sine_q14(10'(ang4[k]) + 10'(QUARTER_TURN));
        sn5[k] <= sine_q14(10'(ang4[k]));
      end
      fx5 <= fx4;
      fy5 <= fy4;
    end
  end

  // stage 6: corner dot products
  assign dxs[0] = $signed({1'b0, fx5});
  assign dxs[1] = $signed({1'b1, fx5});
  assign dys[0] = $signed({1'b0, fy5});
  assign dys[1] = $signed({1'b1, fy5});

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pc[k] = cs5[k] * dxs[k % 2];
      ps[k] = sn5[k] * dys[k / 2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        dot6[k] <= pc[k] + ps[k];
      end
      fx6 <= fx5;
      fy6 <= fy5;
    end
  end

  // stage 7: blend in x
  assign wx0 = ONE - {1'b0, fx6};
  assign wx1 = {1'b0, fx6};

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      qa[j] = dot6[2 * j] * $signed({1'b0, wx0});
      qb[j] = dot6[2 * j + 1] * $signed({1'b0, wx1});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx7[0] <= qa[0] + qb[0];
      nx7[1] <= qa[1] + qb[1];
      fy7    <= fy6;
    end
  end

  // stage 8: blend in y, split into low and high partial products
  assign wy[0] = ONE - {1'b0, fy7};
  assign wy[1] = {1'b0, fy7};

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      lo_next[j] = nx7[j][15:0] * wy[j];
      hi_next[j] = $signed(nx7[j][XW-1:16]) * $signed({1'b0, wy[j]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo8 <= lo_next;
      hi8 <= hi_next;
    end
  end

  // stage 9: recombine partial products
  assign hs = (HPW + 1)'(hi8[0]) + (HPW + 1)'(hi8[1]);
  assign ls = (LW + 1)'(lo8[0]) + (LW + 1)'(lo8[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (adv) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      total9 <= $signed({hs, 16'b0}) + $signed(TW'(ls));
    end
  end

  // output: round half up, saturate
  assign rsum = RW'(total9) + HALF;
  assign shv  = rsum >>> (3 * F);
  assign noise_next = (shv > SAT_HI) ? SAT_HI[NOISE_W-1:0] :
                      (shv < SAT_LO) ? SAT_LO[NOISE_W-1:0] : shv[NOISE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (adv) begin
      ovalid <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      onoise <= noise_next;
    end
  end

endmodule
